### rtl/stel_pkg.sv
// ----------------------------------------------------------------------------
// stel_pkg
// Types, codes and constants shared by the speed trap core and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package stel_pkg;

   localparam int LIMIT_MODULUS_DEFAULT = 100;
   localparam int COUNT_WIDTH_DEFAULT   = 16;

   localparam int SCALE_WIDTH     = 16;
   localparam int TONE_WIDTH      = 10;
   localparam int LIMIT_WIDTH     = 7;
   localparam int TICKS_WIDTH     = 16;
   localparam int SPEED_WIDTH     = 16;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int DIV_CNT_WIDTH   = $clog2(SCALE_WIDTH);

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET     = 16'd30480;
   localparam logic [TONE_WIDTH-1:0]  TONE_LIMIT_RESET = 10'd500;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET     = 7'd20;
   localparam logic [SPEED_WIDTH-1:0] SPEED_SAT       = 16'hFFFF;

   localparam logic [1:0] ACT_MS_TICK    = 2'd0;
   localparam logic [1:0] ACT_PIN_CHANGE = 2'd1;
   localparam logic [1:0] ACT_TONE_TICK  = 2'd2;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_DISTANCE_SCALE = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_TONE_LIMIT     = 3'd4;

   typedef struct packed {
      logic [1:0] action;
      logic       start_sensor_level;
      logic       stop_sensor_level;
      logic       enc_a;
      logic       enc_b;
   } req_type;

   typedef struct packed {
      logic                   measurement_done;
      logic [TICKS_WIDTH-1:0] elapsed_ticks;
      logic [SPEED_WIDTH-1:0] speed;
      logic [LIMIT_WIDTH-1:0] speed_limit;
      logic                   limit_changed;
      logic                   speaker_level;
      logic                   alarm_active;
      logic                   led_on;
      logic                   timing;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic write;
   } ctrl_cmd_type;

   typedef struct packed {
      logic stop_hit;
      logic div_last;
      logic out_free;
   } ctrl_sts_type;

endpackage

`default_nettype wire

### rtl/speed_trap_with_encoder_limit_core.sv
// ----------------------------------------------------------------------------
// speed_trap_with_encoder_limit_core
// Two-gate speed trap with an encoder-set speed limit and a tone alarm.
//
//   channel   ports          direction   payload
//   request   req_*          in          req_type: event kind, pin levels
//   response  rsp_*          out         rsp_type: one status item per event
//   control   csr_*          APB slave   distance_scale, tone_toggle_limit
//
// A tick, tone or non-stop pin item passes from acceptance via the write state
// to the result register; a stop item first runs the 16-step restoring divider.
// One item is in work at a time; a new item is taken while a result waits.
// A stalled result holds the sequencer before its write cycle.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_trap_with_encoder_limit_core
   import stel_pkg::*;
#(
   parameter int LIMIT_MODULUS = LIMIT_MODULUS_DEFAULT,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                           csr_pready
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   assign csr_pready = 1'b1;

   stel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stel_datapath #(
      .LIMIT_MODULUS (LIMIT_MODULUS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

### rtl/stel_ctrl.sv
// ----------------------------------------------------------------------------
// stel_ctrl
// Sequencer: takes an item, runs the divider on a stop event, writes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module stel_ctrl
   import stel_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type      cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.stop_hit ? ST_DIVIDE : ST_WRITE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.write    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_WRITE:  cmd.write    = sts.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/stel_datapath.sv
// ----------------------------------------------------------------------------
// stel_datapath
// Timing, encoder limit, alarm state, control registers, divider, result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module stel_datapath
   import stel_pkg::*;
#(
   parameter int LIMIT_MODULUS = LIMIT_MODULUS_DEFAULT,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]      csr_prdata,
   input  wire ctrl_cmd_type              cmd,
   output ctrl_sts_type                   sts
);

   localparam logic [LIMIT_WIDTH:0]   MOD_EXT  = (LIMIT_WIDTH+1)'(LIMIT_MODULUS);
   localparam logic [LIMIT_WIDTH-1:0] MOD_LAST = LIMIT_WIDTH'(LIMIT_MODULUS - 1);
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(SCALE_WIDTH - 1);

   logic [SCALE_WIDTH-1:0] scale_ff, scale_in;
   logic [TONE_WIDTH-1:0]  tone_limit_ff, tone_limit_in;

   logic                   timing_ff, timing_in;
   logic                   led_ff, led_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   phase_valid_ff, phase_valid_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic                   alarm_ff, alarm_in;
   logic [TONE_WIDTH-1:0]  tone_ff, tone_in;
   logic                   speaker_ff, speaker_in;

   logic [TICKS_WIDTH-1:0] report_ff, report_in;
   logic                   stop_ff, stop_in;
   logic                   changed_ff, changed_in;

   logic [SCALE_WIDTH-1:0] quo_ff, quo_in;
   logic [COUNT_WIDTH:0]   rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] divisor_ff, divisor_in;
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic                   zero_ff, zero_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   csr_write;
   logic                   pin_change;
   logic                   stop_hit;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [31:0]            count_wide;
   logic [1:0]             enc_next;
   logic                   enc_up;
   logic                   enc_down;
   logic [LIMIT_WIDTH:0]   limit_plus;
   logic [TONE_WIDTH:0]    tone_plus;
   logic [COUNT_WIDTH:0]   rem_shift;
   logic [COUNT_WIDTH:0]   rem_diff;
   logic                   rem_ge;
   logic [SPEED_WIDTH-1:0] speed_val;
   logic                   alarm_set;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign pin_change = (req_data.action == ACT_PIN_CHANGE);
   assign stop_hit   = pin_change & req_data.start_sensor_level
                       & ~req_data.stop_sensor_level;

   assign sts.stop_hit = stop_hit;
   assign sts.div_last = (div_cnt_ff == DIV_LAST);
   assign sts.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr)
         REG_DISTANCE_SCALE: csr_prdata = CSR_DATA_WIDTH'(scale_ff);
         REG_TONE_LIMIT:     csr_prdata = CSR_DATA_WIDTH'(tone_limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      scale_in      = scale_ff;
      tone_limit_in = tone_limit_ff;
      if (csr_write && csr_paddr == REG_DISTANCE_SCALE) begin
         scale_in = csr_pwdata[SCALE_WIDTH-1:0];
      end
      if (csr_write && csr_paddr == REG_TONE_LIMIT) begin
         tone_limit_in = csr_pwdata[TONE_WIDTH-1:0];
      end
   end

   // quadrature step from the stored phase
   always_comb begin
      enc_next = phase_ff;
      enc_up   = 1'b0;
      enc_down = 1'b0;
      unique case (phase_ff)
         2'd0: begin
            if (req_data.enc_a) begin
               enc_next = 2'd1; enc_up = 1'b1;
            end else if (req_data.enc_b) begin
               enc_next = 2'd2; enc_down = 1'b1;
            end
         end
         2'd1: begin
            if (req_data.enc_b) begin
               enc_next = 2'd3; enc_up = 1'b1;
            end else if (!req_data.enc_a) begin
               enc_next = 2'd0; enc_down = 1'b1;
            end
         end
         2'd2: begin
            if (!req_data.enc_b) begin
               enc_next = 2'd0; enc_up = 1'b1;
            end else if (req_data.enc_a) begin
               enc_next = 2'd3; enc_down = 1'b1;
            end
         end
         default: begin
            if (!req_data.enc_a) begin
               enc_next = 2'd2; enc_up = 1'b1;
            end else if (!req_data.enc_b) begin
               enc_next = 2'd1; enc_down = 1'b1;
            end
         end
      endcase
   end

   assign count_inc  = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
   assign limit_plus = {1'b0, limit_ff} + 1'b1;
   assign tone_plus  = {1'b0, tone_ff} + 1'b1;

   assign rem_shift = {rem_ff[COUNT_WIDTH-1:0], quo_ff[SCALE_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   assign speed_val = zero_ff ? SPEED_SAT : quo_ff;
   assign alarm_set = cmd.write & stop_ff
                      & (speed_val >= SPEED_WIDTH'(limit_ff));

   always_comb begin
      timing_in      = timing_ff;
      led_in         = led_ff;
      count_in       = count_ff;
      phase_in       = phase_ff;
      phase_valid_in = phase_valid_ff;
      limit_in       = limit_ff;
      alarm_in       = alarm_ff | alarm_set;
      tone_in        = tone_ff;
      speaker_in     = speaker_ff;
      report_in      = report_ff;
      stop_in        = stop_ff;
      changed_in     = changed_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      div_cnt_in     = div_cnt_ff;
      zero_in        = zero_ff;
      count_wide     = 32'(count_ff);

      if (cmd.accept) begin
         stop_in    = stop_hit;
         changed_in = 1'b0;
         unique case (req_data.action)
            ACT_MS_TICK: begin
               if (timing_ff) begin
                  count_in   = count_inc;
                  count_wide = 32'(count_inc);
               end
            end
            ACT_PIN_CHANGE: begin
               if (!req_data.start_sensor_level) begin
                  timing_in = 1'b1;
                  led_in    = 1'b1;
               end else if (!req_data.stop_sensor_level) begin
                  timing_in = 1'b0;
                  led_in    = 1'b0;
                  count_in  = '0;
               end
               if (!phase_valid_ff) begin
                  phase_in       = {req_data.enc_b, req_data.enc_a};
                  phase_valid_in = 1'b1;
               end else begin
                  phase_in   = enc_next;
                  changed_in = (enc_next != phase_ff);
                  if (enc_up) begin
                     limit_in = (limit_plus >= MOD_EXT) ? '0 : limit_plus[LIMIT_WIDTH-1:0];
                  end else if (enc_down) begin
                     limit_in = (limit_ff == '0 || {1'b0, limit_ff} >= MOD_EXT) ?
                                MOD_LAST : limit_ff - 1'b1;
                  end
               end
            end
            ACT_TONE_TICK: begin
               if (alarm_ff) begin
                  speaker_in = ~speaker_ff;
                  if (tone_plus > {1'b0, tone_limit_ff}) begin
                     alarm_in = 1'b0;
                     tone_in  = '0;
                  end else begin
                     tone_in = tone_plus[TONE_WIDTH-1:0];
                  end
               end
            end
            default: ;
         endcase
         report_in  = count_wide[TICKS_WIDTH-1:0];
         quo_in     = scale_ff;
         rem_in     = '0;
         divisor_in = count_ff;
         div_cnt_in = '0;
         zero_in    = (count_ff == '0);
      end else if (cmd.div_step) begin
         quo_in     = {quo_ff[SCALE_WIDTH-2:0], rem_ge};
         rem_in     = rem_ge ? rem_diff : rem_shift;
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_data_in                  = rsp_data_ff;
      rsp_valid_in                 = rsp_valid_ff & rsp_stall;
      if (cmd.write) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.measurement_done = stop_ff;
         rsp_data_in.elapsed_ticks    = report_ff;
         rsp_data_in.speed            = stop_ff ? speed_val : '0;
         rsp_data_in.speed_limit      = limit_ff;
         rsp_data_in.limit_changed    = changed_ff;
         rsp_data_in.speaker_level    = speaker_ff;
         rsp_data_in.alarm_active     = alarm_ff | alarm_set;
         rsp_data_in.led_on           = led_ff;
         rsp_data_in.timing           = timing_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff       <= SCALE_RESET;
         tone_limit_ff  <= TONE_LIMIT_RESET;
         timing_ff      <= 1'b0;
         led_ff         <= 1'b0;
         count_ff       <= '0;
         phase_ff       <= '0;
         phase_valid_ff <= 1'b0;
         limit_ff       <= LIMIT_RESET;
         alarm_ff       <= 1'b0;
         tone_ff        <= '0;
         speaker_ff     <= 1'b0;
         stop_ff        <= 1'b0;
         changed_ff     <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         scale_ff       <= scale_in;
         tone_limit_ff  <= tone_limit_in;
         timing_ff      <= timing_in;
         led_ff         <= led_in;
         count_ff       <= count_in;
         phase_ff       <= phase_in;
         phase_valid_ff <= phase_valid_in;
         limit_ff       <= limit_in;
         alarm_ff       <= alarm_in;
         tone_ff        <= tone_in;
         speaker_ff     <= speaker_in;
         stop_ff        <= stop_in;
         changed_ff     <= changed_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      report_ff   <= report_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
